// ===== rtl/vn_pkg.sv =====
// Shared types and constants for the vector normalizer.
`timescale 1ns / 1ps
package vn_pkg;

	localparam int QDEPTH = 4;
	localparam logic [15:0] MIN_LEN_RST = 16'd1;
	localparam logic [31:0] SUM_ONE = 32'd65536;
	localparam logic [15:0] UNIT_ONE = 16'd16384;

	typedef struct packed {
		logic signed [15:0] in_x;
		logic signed [15:0] in_y;
		logic signed [15:0] in_z;
	} vn_in_t;

	typedef struct packed {
		logic signed [15:0] unit_x;
		logic signed [15:0] unit_y;
		logic signed [15:0] unit_z;
		logic [15:0] length;
		logic degenerate;
	} vn_out_t;

	// classified request handed from front to back
	typedef struct packed {
		logic [2:0][30:0] m2;
		logic [2:0][15:0] pv;
		logic [2:0] sgn;
		logic [31:0] s;
		logic passthru;
		logic deg;
	} vn_entry_t;

endpackage

// ===== rtl/vn_front.sv =====
// Front end: squares, sum of squares and classification of each request.
`timescale 1ns / 1ps
module vn_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input vn_pkg::vn_in_t item,
	input logic cfg_valid,
	input logic [15:0] cfg_data,
	output logic q_wr,
	output vn_pkg::vn_entry_t q_wdata,
	input logic q_full
);
	import vn_pkg::*;

	logic [15:0] min_length_q;
	logic [31:0] minsq_q;
	logic v_s1, v_s2;
	logic [2:0][30:0] m2_s1;
	logic [2:0][15:0] pv_s1;
	logic [2:0] sgn_s1;
	vn_entry_t ent_s2;
	logic fen;
	logic [2:0][15:0] comp;
	logic [2:0][30:0] m2_d;
	logic [2:0][15:0] pv_d;
	logic [31:0] s_d;
	logic unit_d, short_d;

	assign fen = !(v_s2 && q_full);
	assign full = !fen;
	assign q_wr = v_s2 && !q_full;
	assign q_wdata = ent_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MIN_LEN_RST;
			minsq_q <= 32'd1;
		end else begin
			if (cfg_valid) min_length_q <= cfg_data;
			minsq_q <= 32'(min_length_q) * 32'(min_length_q);
		end
	end

	assign comp[0] = item.in_x;
	assign comp[1] = item.in_y;
	assign comp[2] = item.in_z;

	always_comb begin
		logic signed [31:0] p;
		logic signed [21:0] v;
		for (int i = 0; i < 3; i++) begin
			p = $signed({{16{comp[i][15]}}, comp[i]}) * $signed({{16{comp[i][15]}}, comp[i]});
			m2_d[i] = p[30:0];
			v = {comp[i], 6'b0};
			if (v > $signed({6'b0, UNIT_ONE})) pv_d[i] = UNIT_ONE;
			else if (v < -$signed({6'b0, UNIT_ONE})) pv_d[i] = -UNIT_ONE;
			else pv_d[i] = v[15:0];
		end
	end

	// stage 1: squares and pass-through values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (fen) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (fen) begin
			m2_s1 <= m2_d;
			pv_s1 <= pv_d;
			for (int i = 0; i < 3; i++) sgn_s1[i] <= comp[i][15];
		end
	end

	// stage 2: sum and classify
	assign s_d = 32'(m2_s1[0]) + 32'(m2_s1[1]) + 32'(m2_s1[2]);
	assign unit_d = (s_d == SUM_ONE);
	assign short_d = (s_d == 32'd0) || (s_d < minsq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (fen) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fen) begin
			ent_s2.m2 <= m2_s1;
			ent_s2.pv <= pv_s1;
			ent_s2.sgn <= sgn_s1;
			ent_s2.s <= s_d;
			ent_s2.passthru <= unit_d || short_d;
			ent_s2.deg <= short_d && !unit_d;
		end
	end

endmodule

// ===== rtl/vn_fifo.sv =====
// Short request queue between front and back.
`timescale 1ns / 1ps
module vn_fifo #(
	parameter int DEPTH = vn_pkg::QDEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input vn_pkg::vn_entry_t wdata,
	output logic full,
	input logic rd,
	output vn_pkg::vn_entry_t rdata,
	output logic empty
);
	import vn_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	vn_entry_t mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			if (do_rd) rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			if (do_wr && !do_rd) cnt_q <= cnt_q + CW'(1);
			else if (do_rd && !do_wr) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ===== rtl/vn_back.sv =====
// Back end: pipelined root, divisions and rounding, with the result register.
`timescale 1ns / 1ps
module vn_back (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input vn_pkg::vn_entry_t q_rdata,
	output logic q_rd,
	output logic empty,
	input logic pop,
	output vn_pkg::vn_out_t result
);
	import vn_pkg::*;

	localparam int NDIV = 31;
	localparam int LSQ = 16;
	localparam int DSQ = 16;
	localparam int NST = NDIV + DSQ;

	typedef struct packed {
		logic [17:0] rem;
		logic [15:0] root;
	} sq_t;

	typedef struct packed {
		logic [31:0] s;
		logic [31:0] lsrc;
		logic [17:0] lrem;
		logic [15:0] lroot;
		logic [15:0] len;
		logic [2:0][31:0] r;
		logic [2:0][30:0] q;
		logic [2:0][31:0] dsrc;
		logic [2:0][17:0] rem;
		logic [2:0][15:0] root;
		logic [2:0][15:0] pv;
		logic [2:0] sgn;
		logic passthru;
		logic deg;
	} st_t;

	function automatic sq_t sq_step(input logic [17:0] rem, input logic [15:0] root,
			input logic [1:0] two);
		sq_t res;
		logic [19:0] t;
		logic [19:0] trial;
		t = {rem, two};
		trial = {2'b0, root, 2'b01};
		if (t >= trial) begin
			res.rem = 18'(t - trial);
			res.root = {root[14:0], 1'b1};
		end else begin
			res.rem = t[17:0];
			res.root = {root[14:0], 1'b0};
		end
		return res;
	endfunction

	st_t st_q [NST];
	st_t st_d [NST];
	logic [NST-1:0] vld_q;
	logic out_vld_q;
	vn_out_t res_q;
	vn_out_t res_d;
	logic be;

	assign be = !out_vld_q || pop;
	assign q_rd = be && !q_empty;
	assign empty = !out_vld_q;
	assign result = res_q;

	for (genvar k = 0; k < NST; k++) begin : g_st
		always_comb begin
			st_t b;
			sq_t sr;
			logic [32:0] t;
			logic sb;
			sr = '0;
			t = '0;
			sb = 1'b0;
			if (k == 0) begin
				b = '0;
				b.s = q_rdata.s;
				b.lsrc = q_rdata.s;
				b.pv = q_rdata.pv;
				b.sgn = q_rdata.sgn;
				b.passthru = q_rdata.passthru;
				b.deg = q_rdata.deg;
				for (int i = 0; i < 3; i++) b.r[i] = {2'b0, q_rdata.m2[i][30:1]};
			end else begin
				b = st_q[(k > 0) ? k - 1 : 0];
			end
			// length root, two bits a stage
			if (k < LSQ) begin
				sr = sq_step(b.lrem, b.lroot, b.lsrc[31:30]);
				b.lrem = sr.rem;
				b.lroot = sr.root;
				b.lsrc = {b.lsrc[29:0], 2'b00};
			end
			if (k == LSQ) begin
				b.len = (b.lrem > {2'b0, b.lroot}) ? b.lroot + 16'd1 : b.lroot;
			end
			// D = m2 * 2^30 / S, one quotient bit a stage
			if (k < NDIV) begin
				for (int i = 0; i < 3; i++) begin
					sb = (k == 0) ? q_rdata.m2[i][0] : 1'b0;
					t = {b.r[i], sb};
					if (t >= {1'b0, b.s}) begin
						b.r[i] = 32'(t - {1'b0, b.s});
						b.q[i] = {b.q[i][29:0], 1'b1};
					end else begin
						b.r[i] = t[31:0];
						b.q[i] = {b.q[i][29:0], 1'b0};
					end
				end
			end else begin
				// root of D gives floor(2 * c * 2^14 / |v|)
				for (int i = 0; i < 3; i++) begin
					if (k == NDIV) b.dsrc[i] = {1'b0, b.q[i]};
					sr = sq_step(b.rem[i], b.root[i], b.dsrc[i][31:30]);
					b.rem[i] = sr.rem;
					b.root[i] = sr.root;
					b.dsrc[i] = {b.dsrc[i][29:0], 2'b00};
				end
			end
			st_d[k] = b;
		end

		always_ff @(posedge clk) begin
			if (be) st_q[k] <= st_d[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
		end else if (be) begin
			vld_q <= {vld_q[NST-2:0], !q_empty};
			out_vld_q <= vld_q[NST-1];
		end
	end

	// halve with round up, clamp, sign, or pass through
	always_comb begin
		logic [2:0][15:0] u;
		logic [16:0] h;
		logic [15:0] m;
		for (int i = 0; i < 3; i++) begin
			h = {1'b0, st_q[NST-1].root[i]} + 17'd1;
			m = h[16:1];
			if (m > UNIT_ONE) m = UNIT_ONE;
			if (st_q[NST-1].passthru) u[i] = st_q[NST-1].pv[i];
			else u[i] = st_q[NST-1].sgn[i] ? -m : m;
		end
		res_d.unit_x = u[0];
		res_d.unit_y = u[1];
		res_d.unit_z = u[2];
		res_d.length = st_q[NST-1].len;
		res_d.degenerate = st_q[NST-1].deg;
	end

	always_ff @(posedge clk) begin
		if (be) res_q <= res_d;
	end

endmodule

// ===== rtl/vector3_normalize.sv =====
// Throughput: one vector per cycle while each result is popped as it appears;
// the back end holds a 47-stage root/divide pipeline.
// The back pipeline advances whenever its result register is free or being popped.
// Reset (arst_n low, async): queues and pipelines empty, min_length = 1.
// The front keeps accepting into the request queue while a result waits.
`timescale 1ns / 1ps
module vector3_normalize #(
	parameter int FIFO_DEPTH = vn_pkg::QDEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input vn_pkg::vn_in_t item,
	output logic empty,
	input logic pop,
	output vn_pkg::vn_out_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [15:0] cfg_data
);
	import vn_pkg::*;

	logic q_wr, q_full, q_rd, q_empty;
	vn_entry_t q_wdata, q_rdata;

	// register write always taken
	assign cfg_ready = 1'b1;

	// front: square, sum, classify unit/short vectors
	vn_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.q_wr(q_wr),
		.q_wdata(q_wdata),
		.q_full(q_full)
	);

	// decoupling queue, lets front and back stall independently
	vn_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr(q_wr),
		.wdata(q_wdata),
		.full(q_full),
		.rd(q_rd),
		.rdata(q_rdata),
		.empty(q_empty)
	);

	// back: length root, quotient, component roots, rounding
	vn_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_rdata(q_rdata),
		.q_rd(q_rd),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule

// ===== tb/vector3_normalize_test.sv =====
// Self-checking testbench for the vector normalizer: random and directed vectors, scored.
`timescale 1ns / 1ps
module vector3_normalize_test;
	import vn_pkg::*;

	localparam int STALL_LIMIT = 5000;   // cycles with no request or result moving
	localparam int TAIL_CYCLES = 80;     // pipeline is 51 deep
	localparam int HOLD_CYCLES = 400;    // long receiver hold-off to back up the block

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic [15:0] cfg_data = '0;
	vn_in_t item = '0;
	logic full, empty, cfg_ready;
	vn_out_t result;

	// stimulus waiting to be offered, and results the block still owes us
	vn_in_t vec_queue[$];
	vn_out_t norm_queue[$];
	logic [15:0] min_len = MIN_LEN_RST;
	bit quiet = 1'b0;        // no idling near the end of the run
	int n_sent = 0, n_recv = 0, n_errors = 0, n_degen = 0, n_unit_pass = 0;
	int idle_cycles = 0;

	vector3_normalize dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Exact normalization: floor root of the sum of squares, then a bitwise
	// search for round(c * 2^14 / sqrt(S)), ties away from zero.
	function automatic vn_out_t normalize_vec(vn_in_t v, logic [15:0] min_l);
		longint c[3];
		longint u[3];
		longint unsigned s, r, t, mag, a, a2, q, odd, lim;
		vn_out_t o;
		bit pass_thru, deg;
		int i, b;
		c[0] = v.in_x;
		c[1] = v.in_y;
		c[2] = v.in_z;
		s = 0;
		for (i = 0; i < 3; i++)
			s += longint'(c[i] * c[i]);
		r = 0;
		for (b = 16; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= s)
				r = t;
		end
		lim = {48'd0, min_l};
		pass_thru = 1'b1;
		deg = 1'b0;
		if (s == 64'(SUM_ONE)) begin
			deg = 1'b0;
		end else if (s == 0 || s < lim * lim) begin
			deg = 1'b1;
		end else begin
			pass_thru = 1'b0;
		end
		for (i = 0; i < 3; i++) begin
			if (pass_thru) begin
				u[i] = c[i] * 64;
				if (u[i] > 16384) u[i] = 16384;
				if (u[i] < -16384) u[i] = -16384;
			end else begin
				mag = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
				a = mag << 14;
				a2 = a * a;
				q = 0;
				for (b = 14; b >= 0; b--) begin
					t = q | (64'd1 << b);
					if (t * t * s <= a2)
						q = t;
				end
				odd = 2 * q + 1;
				if (4 * a2 >= odd * odd * s)
					q++;
				if (q > 16384) q = 16384;
				u[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
			end
		end
		o.unit_x = u[0][15:0];
		o.unit_y = u[1][15:0];
		o.unit_z = u[2][15:0];
		o.length = (s > r * r + r) ? 16'(r + 1) : 16'(r);
		o.degenerate = deg;
		return o;
	endfunction

	// Random vector mix: full range, small, unit axes, tiny, and corner values.
	function automatic vn_in_t rand_vec();
		vn_in_t v;
		logic [15:0] corners[5];
		int axis;
		corners = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
		v = '0;
		case ($urandom % 8)
			0, 1, 2: begin
				v = {16'($urandom), 16'($urandom), 16'($urandom)};
			end
			3, 4: begin
				v.in_x = 16'($urandom_range(600) - 300);
				v.in_y = 16'($urandom_range(600) - 300);
				v.in_z = 16'($urandom_range(600) - 300);
			end
			5: begin
				axis = $urandom % 3;
				if (axis == 0) v.in_x = $urandom % 2 ? 16'sd256 : -16'sd256;
				if (axis == 1) v.in_y = $urandom % 2 ? 16'sd256 : -16'sd256;
				if (axis == 2) v.in_z = $urandom % 2 ? 16'sd256 : -16'sd256;
			end
			6: begin
				v.in_x = 16'($urandom_range(6) - 3);
				v.in_y = 16'($urandom_range(6) - 3);
				v.in_z = 16'($urandom_range(6) - 3);
			end
			default: begin
				v.in_x = corners[$urandom % 5];
				v.in_y = corners[$urandom % 5];
				v.in_z = corners[$urandom % 5];
			end
		endcase
		return v;
	endfunction

	// Request driver: holds a request until accepted, idles in random bursts.
	int send_gap = 0;
	always @(posedge clk) begin
		bit offering;
		offering = push;
		if (push && !full) begin
			norm_queue.push_back(normalize_vec(item, min_len));
			void'(vec_queue.pop_front());
			n_sent++;
			offering = 1'b0;
		end
		if (!offering) begin
			if (send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (vec_queue.size() > 0) begin
				if (!quiet && $urandom % 10 == 0) begin
					send_gap = $urandom_range(11, 0);
					push <= 1'b0;
				end else begin
					push <= 1'b1;
					item <= vec_queue[0];
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Result monitor: scores each popped result against the oldest prediction.
	int recv_gap = 0;
	bit held_once = 1'b0;
	always @(posedge clk) begin
		vn_out_t want;
		if (pop && !empty) begin
			n_recv++;
			if (result.degenerate) n_degen++;
			if (norm_queue.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result %h at %0t", result, $realtime);
			end else begin
				want = norm_queue.pop_front();
				if (result.unit_x !== want.unit_x || result.unit_y !== want.unit_y ||
				    result.unit_z !== want.unit_z || result.length !== want.length ||
				    result.degenerate !== want.degenerate) begin
					n_errors++;
					if (n_errors <= 10) begin
						$display("mismatch #%0d: exp u=(%0d %0d %0d) len=%0d deg=%0d",
							n_recv, want.unit_x, want.unit_y, want.unit_z,
							want.length, want.degenerate);
						$display("  got u=(%0d %0d %0d) len=%0d deg=%0d",
							result.unit_x, result.unit_y, result.unit_z,
							result.length, result.degenerate);
					end
				end
			end
		end
		// one long hold-off so the block fills and pushes back on requests
		if (!held_once && n_sent >= 250) begin
			held_once = 1'b1;
			recv_gap = HOLD_CYCLES;
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			pop <= 1'b0;
		end else if (!quiet && $urandom % 10 == 0) begin
			recv_gap = $urandom_range(11, 0);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// Watchdog: any request or result moving resets the count.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("stalled: %0d sent, %0d received", n_sent, n_recv);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_min_len(input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		min_len = val;
	endtask

	// let everything drain, plus the pipeline depth, before touching the register
	task automatic drain();
		wait (vec_queue.size() == 0 && !push && norm_queue.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic add_random(input int count);
		repeat (count) vec_queue.push_back(rand_vec());
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset tolerance, zero, unit axes, extremes, short vectors
		vec_queue.push_back('{16'sd0, 16'sd0, 16'sd0});
		vec_queue.push_back('{16'sd256, 16'sd0, 16'sd0});
		vec_queue.push_back('{16'sd0, -16'sd256, 16'sd0});
		vec_queue.push_back('{16'sd0, 16'sd0, -16'sd256});
		vec_queue.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
		vec_queue.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
		vec_queue.push_back('{16'sh8000, 16'sd0, 16'sd0});
		vec_queue.push_back('{16'sh7fff, 16'sh8000, 16'sd1});
		vec_queue.push_back('{16'sd1, 16'sd0, 16'sd0});
		vec_queue.push_back('{-16'sd1, -16'sd1, -16'sd1});
		vec_queue.push_back('{16'sd3, 16'sd4, 16'sd0});
		vec_queue.push_back('{16'sd128, 16'sd128, 16'sd128});
		vec_queue.push_back('{16'sd1, 16'sd255, 16'sd0});
		add_random(300);
		drain();

		// zero tolerance: zero vector must still be degenerate
		write_min_len(16'd0);
		vec_queue.push_back('{16'sd0, 16'sd0, 16'sd0});
		vec_queue.push_back('{16'sd0, 16'sd1, 16'sd0});
		add_random(300);
		drain();

		// max tolerance: everything short except exact unit, with saturation
		write_min_len(16'hffff);
		vec_queue.push_back('{16'sd256, 16'sd0, 16'sd0});
		vec_queue.push_back('{16'sh7fff, -16'sd300, 16'sd5});
		add_random(200);
		drain();

		// tolerance of 1.0: split between short and normalized
		write_min_len(16'd256);
		vec_queue.push_back('{16'sd255, 16'sd0, 16'sd0});
		vec_queue.push_back('{16'sd0, 16'sd0, 16'sd257});
		add_random(300);
		drain();

		write_min_len(16'($urandom_range(400)));
		add_random(350);
		drain();

		// last stretch runs without idling on either side
		write_min_len(16'd1);
		quiet = 1'b1;
		add_random(250);
		drain();

		if (norm_queue.size() != 0) begin
			n_errors++;
			$display("%0d results never arrived", norm_queue.size());
		end
		$display("covered %0d vectors over six tolerance settings (0, 1, 1.0, max, random)",
			n_sent);
		$display("%0d results checked, %0d degenerate, %0d mismatches",
			n_recv, n_degen, n_errors);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/vn_pkg.sv
rtl/vn_front.sv
rtl/vn_fifo.sv
rtl/vn_back.sv
rtl/vector3_normalize.sv
tb/vector3_normalize_test.sv
